@@ hw/rtl/bab_pkg.sv @@
package bab_pkg;

  localparam int MinOrder    = 4;
  localparam int ArenaOrder  = 20;
  localparam int HeaderBytes = 8;
  localparam int AlignBytes  = 16;

  localparam int TotalBits = 1 << (ArenaOrder - MinOrder + 1);
  localparam int MapWords  = TotalBits / 64;
  localparam int WordAw    = $clog2(MapWords);
  localparam int BitAw     = WordAw + 6;

  localparam logic FuncAlloc  = 1'b0;
  localparam logic FuncFree   = 1'b1;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SPLIT_RD,
    ST_SPLIT_WR,
    ST_FSET_RD,
    ST_FSET_WR,
    ST_BUD_RD,
    ST_BUD_CHK,
    ST_CCLR_RD,
    ST_CCLR_WR,
    ST_OUT
  } state_t;

  function automatic logic [BitAw-1:0] bit_pos(input logic [4:0] ord,
                                                input logic [19:0] idx);
    logic [BitAw:0] base;
    base = (BitAw+1)'(1) << (5'(ArenaOrder) - ord);
    return BitAw'(base - (BitAw+1)'(1) + (BitAw+1)'(idx));
  endfunction

endpackage

@@ hw/rtl/buddy_allocator_bitmap.sv @@
// Allocate scans the bitmap a word at a time (at most 2064 words scanned), then splits
//   down one level at a time to the wanted order; free sets the block's bit and merges
//   with a free buddy level by level, ending with a final buddy check below the top order;
//   an oversize allocate or a bad-order free goes straight to the result beat.
// Throughput: one request at a time; the next beat is taken in the cycle after the
//   result beat leaves. Reset: synchronous; a clearing pass writes all 2048 words,
//   zeroing the bitmap and marking the whole-arena block free, input stalled meanwhile.
module buddy_allocator_bitmap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [20:0] payload_bytes,
  input  logic [19:0] free_offset,
  input  logic [4:0]  free_order,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [19:0] block_offset,
  output logic [4:0]  block_order
);

  localparam int WA = bab_pkg::WordAw;
  localparam int BA = bab_pkg::BitAw;

  logic [63:0]   mem [bab_pkg::MapWords];
  logic [63:0]   rdata;
  logic          we;
  logic [WA-1:0] waddr;
  logic [WA-1:0] raddr;
  logic [63:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  bab_pkg::state_t state, state_next;
  logic [WA-1:0] cnt;
  logic [4:0]    want;
  logic [4:0]    ord;
  logic [BA:0]   pos;
  logic [19:0]   idx;
  logic          res_status;
  logic [19:0]   res_off;
  logic [4:0]    res_ord;

  assign status       = res_status;
  assign block_offset = res_off;
  assign block_order  = res_ord;

  logic [22:0] need_raw;
  logic [22:0] need;
  logic [4:0]  want_c;
  logic        too_big;
  logic        bad_order;
  always_comb begin
    need_raw = 23'(payload_bytes)
             + 23'(bab_pkg::HeaderBytes + bab_pkg::AlignBytes - 1);
    need = need_raw & ~23'(bab_pkg::AlignBytes - 1);
    want_c = 5'(bab_pkg::MinOrder);
    for (int k = bab_pkg::ArenaOrder; k >= bab_pkg::MinOrder; k--)
      if ((23'(1) << k) >= need) want_c = 5'(k);
    too_big = need > (23'(1) << bab_pkg::ArenaOrder);
    bad_order = (free_order < 5'(bab_pkg::MinOrder))
             || (free_order > 5'(bab_pkg::ArenaOrder));
  end

  logic [19:0]   sel_idx;
  logic [BA-1:0] tgt_bit;
  logic [63:0]   tgt_mask;
  logic [BA-1:0] lbase;
  logic [BA:0]   lend;
  logic [BA:0]   next_pos;
  logic [63:0]   masked;
  logic [5:0]    tz;
  logic [BA:0]   hit_pos;
  logic          hit;
  logic [19:0]   hit_idx;
  always_comb begin
    case (state)
      bab_pkg::ST_SPLIT_RD, bab_pkg::ST_SPLIT_WR: sel_idx = idx | 20'd1;
      bab_pkg::ST_BUD_RD, bab_pkg::ST_BUD_CHK:    sel_idx = idx ^ 20'd1;
      default:                                    sel_idx = idx;
    endcase
    tgt_bit  = bab_pkg::bit_pos(ord, sel_idx);
    tgt_mask = 64'd1 << tgt_bit[5:0];
    lbase    = bab_pkg::bit_pos(ord, 20'd0);
    lend     = {lbase, 1'b1};
    next_pos = (pos | (BA+1)'(63)) + (BA+1)'(1);
    masked   = rdata & ({64{1'b1}} << pos[5:0]);
    tz = '0;
    for (int k = 63; k >= 0; k--) if (masked[k]) tz = 6'(k);
    hit_pos = {pos[BA:6], tz};
    hit     = (masked != '0) && (hit_pos < lend);
    hit_idx = 20'(hit_pos - {1'b0, lbase});
  end

  always_comb begin
    state_next = state;
    case (state)
      bab_pkg::ST_CLEAR: if (cnt == WA'(bab_pkg::MapWords - 1)) state_next = bab_pkg::ST_IDLE;
      bab_pkg::ST_IDLE: if (in_valid) begin
        if (func == bab_pkg::FuncAlloc)
          state_next = too_big ? bab_pkg::ST_OUT : bab_pkg::ST_SCAN_RD;
        else
          state_next = bad_order ? bab_pkg::ST_OUT : bab_pkg::ST_FSET_RD;
      end
      bab_pkg::ST_SCAN_RD: state_next = bab_pkg::ST_SCAN_CHK;
      bab_pkg::ST_SCAN_CHK: begin
        if (hit)
          state_next = (ord == want) ? bab_pkg::ST_OUT : bab_pkg::ST_SPLIT_RD;
        else if (next_pos >= lend && ord == 5'(bab_pkg::ArenaOrder))
          state_next = bab_pkg::ST_OUT;
        else
          state_next = bab_pkg::ST_SCAN_RD;
      end
      bab_pkg::ST_SPLIT_RD: state_next = bab_pkg::ST_SPLIT_WR;
      bab_pkg::ST_SPLIT_WR:
        state_next = (ord == want) ? bab_pkg::ST_OUT : bab_pkg::ST_SPLIT_RD;
      bab_pkg::ST_FSET_RD: state_next = bab_pkg::ST_FSET_WR;
      bab_pkg::ST_FSET_WR:
        state_next = (ord == 5'(bab_pkg::ArenaOrder)) ? bab_pkg::ST_OUT : bab_pkg::ST_BUD_RD;
      bab_pkg::ST_BUD_RD: state_next = bab_pkg::ST_BUD_CHK;
      bab_pkg::ST_BUD_CHK:
        state_next = ((rdata & tgt_mask) != '0) ? bab_pkg::ST_CCLR_RD : bab_pkg::ST_OUT;
      bab_pkg::ST_CCLR_RD: state_next = bab_pkg::ST_CCLR_WR;
      bab_pkg::ST_CCLR_WR: state_next = bab_pkg::ST_FSET_RD;
      bab_pkg::ST_OUT: if (!out_stall) state_next = bab_pkg::ST_IDLE;
      default: state_next = bab_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    waddr     = tgt_bit[BA-1:6];
    wdata     = rdata | tgt_mask;
    raddr     = tgt_bit[BA-1:6];
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      bab_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = (cnt == '0) ? 64'd1 : 64'd0;
      end
      bab_pkg::ST_IDLE: in_stall = 1'b0;
      bab_pkg::ST_SCAN_RD: raddr = pos[BA-1:6];
      bab_pkg::ST_SCAN_CHK: begin
        we    = hit;
        waddr = pos[BA-1:6];
        wdata = rdata & ~(64'd1 << tz);
      end
      bab_pkg::ST_SPLIT_WR, bab_pkg::ST_FSET_WR: we = 1'b1;
      bab_pkg::ST_BUD_CHK: begin
        we    = (rdata & tgt_mask) != '0;
        wdata = rdata & ~tgt_mask;
      end
      bab_pkg::ST_CCLR_WR: begin
        we    = 1'b1;
        wdata = rdata & ~tgt_mask;
      end
      bab_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bab_pkg::ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        bab_pkg::ST_CLEAR: cnt <= cnt + 1'b1;
        bab_pkg::ST_IDLE: if (in_valid) begin
          res_status <= (func == bab_pkg::FuncAlloc && too_big) ? bab_pkg::StatusFail
                                                                : bab_pkg::StatusOk;
          res_off <= '0;
          res_ord <= '0;
          if (func == bab_pkg::FuncAlloc) begin
            want <= want_c;
            ord  <= want_c;
            pos  <= {1'b0, bab_pkg::bit_pos(want_c, 20'd0)};
          end else begin
            ord <= free_order;
            idx <= free_offset >> free_order;
          end
        end
        bab_pkg::ST_SCAN_CHK: begin
          if (hit) begin
            if (ord == want) begin
              res_off <= hit_idx << want;
              res_ord <= want;
            end else begin
              ord <= ord - 1'b1;
              idx <= hit_idx << 1;
            end
          end else if (next_pos >= lend) begin
            if (ord == 5'(bab_pkg::ArenaOrder)) res_status <= bab_pkg::StatusFail;
            else begin
              ord <= ord + 1'b1;
              pos <= {1'b0, lbase >> 1};
            end
          end else pos <= next_pos;
        end
        bab_pkg::ST_SPLIT_WR: begin
          if (ord == want) begin
            res_off <= idx << want;
            res_ord <= want;
          end else begin
            ord <= ord - 1'b1;
            idx <= idx << 1;
          end
        end
        bab_pkg::ST_CCLR_WR: begin
          ord <= ord + 1'b1;
          idx <= idx >> 1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/bab_checker.sv @@
module bab_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func,
  input  logic [20:0] payload_bytes,
  input  logic [19:0] free_offset,
  input  logic [4:0]  free_order,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        status,
  input  logic [19:0] block_offset,
  input  logic [4:0]  block_order,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        st;
    logic [19:0] off;
    logic [4:0]  ord;
  } alloc_res_t;

  bit          free_map [bab_pkg::TotalBits];
  alloc_res_t  expected_q[$];

  function automatic int map_index(int ord, int idx);
    return (1 << (bab_pkg::ArenaOrder - ord)) - 1 + idx;
  endfunction

  function automatic alloc_res_t model_request(logic f, logic [20:0] pay,
                                               logic [19:0] off, logic [4:0] ordv);
    alloc_res_t r;
    int need, want, o, idx, cnt, ord, i;
    bit found;
    r = '0;
    if (f == bab_pkg::FuncAlloc) begin
      need = bab_pkg::HeaderBytes + int'(pay);
      need = (need + bab_pkg::AlignBytes - 1) / bab_pkg::AlignBytes * bab_pkg::AlignBytes;
      want = bab_pkg::MinOrder;
      while (want <= bab_pkg::ArenaOrder && (1 << want) < need) want++;
      if (want > bab_pkg::ArenaOrder) begin
        r.st = bab_pkg::StatusFail;
        return r;
      end
      for (o = want; o <= bab_pkg::ArenaOrder; o++) begin
        cnt = 1 << (bab_pkg::ArenaOrder - o);
        found = 0;
        for (i = 0; i < cnt; i++) begin
          if (free_map[map_index(o, i)]) begin
            found = 1;
            idx = i;
            break;
          end
        end
        if (!found) continue;
        free_map[map_index(o, idx)] = 0;
        while (o > want) begin
          o--;
          idx = idx << 1;
          free_map[map_index(o, idx + 1)] = 1;
        end
        r.off = 20'(idx << want);
        r.ord = 5'(want);
        return r;
      end
      r.st = bab_pkg::StatusFail;
      return r;
    end
    if (ordv < bab_pkg::MinOrder || ordv > bab_pkg::ArenaOrder) return r;
    ord = int'(ordv);
    idx = int'(off) >> ord;
    if (idx >= (1 << (bab_pkg::ArenaOrder - ord))) return r;
    free_map[map_index(ord, idx)] = 1;
    while (ord < bab_pkg::ArenaOrder) begin
      if (!free_map[map_index(ord, idx ^ 1)]) break;
      free_map[map_index(ord, idx ^ 1)] = 0;
      free_map[map_index(ord, idx)] = 0;
      idx = idx >> 1;
      ord++;
      free_map[map_index(ord, idx)] = 1;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alloc_res_t got, want_r;
    int errs;
    errs = 0;
    if (rst) begin
      foreach (free_map[i]) free_map[i] = 0;
      free_map[0] = 1;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status, block_offset, block_order};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat exp none got st=%0d off=%h ord=%0d",
                   $time, status, block_offset, block_order);
          errs++;
        end else begin
          want_r = expected_q.pop_front();
          if (got.st !== want_r.st) begin
            $display("%0t: status exp %0d got %0d", $time, want_r.st, got.st);
            errs++;
          end
          if (got.off !== want_r.off) begin
            $display("%0t: block_offset exp %h got %h", $time, want_r.off, got.off);
            errs++;
          end
          if (got.ord !== want_r.ord) begin
            $display("%0t: block_order exp %0d got %0d", $time, want_r.ord, got.ord);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(model_request(func, payload_bytes, free_offset, free_order));
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ tb/tb_buddy_allocator_bitmap.sv @@
module tb_buddy_allocator_bitmap;

  localparam int   WATCHDOG   = 40000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic        func = 0;
  logic [20:0] payload_bytes = 0;
  logic [19:0] free_offset = 0;
  logic [4:0]  free_order = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        status;
  logic [19:0] block_offset;
  logic [4:0]  block_order;
  int          fail_count;
  int          pending;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_off = 0;
  int   idle_cycles = 0;

  logic [19:0] live_off[$];
  logic [4:0]  live_ord[$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  buddy_allocator_bitmap dut (.*);

  bab_checker chk (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("buddy_allocator_bitmap regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_beat(logic f, logic [20:0] pay, logic [19:0] off, logic [4:0] ord);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid      <= 1;
    func          <= f;
    payload_bytes <= pay;
    free_offset   <= off;
    free_order    <= ord;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // track allocations from the dut outputs so frees hit live blocks
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && status == bab_pkg::StatusOk && block_order != 0) begin
      live_off.push_back(block_offset);
      live_ord.push_back(block_order);
    end
  end

  task automatic random_beat;
    int r, k;
    logic [20:0] pay;
    r = $urandom_range(99);
    if (r < 45) begin
      case ($urandom_range(3))
        0: pay = 21'($urandom_range(64));
        1: pay = 21'($urandom_range(4096));
        2: pay = 21'($urandom_range(65536));
        default: pay = 21'($urandom);
      endcase
      send_beat(bab_pkg::FuncAlloc, pay, 20'($urandom), 5'($urandom));
    end else if (r < 85 && live_off.size() > 0) begin
      k = $urandom_range(live_off.size() - 1);
      send_beat(bab_pkg::FuncFree, 21'($urandom), live_off[k] | 20'($urandom_range(15)),
                live_ord[k]);
      live_off.delete(k);
      live_ord.delete(k);
    end else begin
      send_beat(bab_pkg::FuncFree, 21'($urandom), 20'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    int i, ph;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_beat(bab_pkg::FuncAlloc, 21'd0, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd8, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd9, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd1000, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'h1FFFFF, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd1048576, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd0, 5'd3);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'hFFFFF, 5'd21);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'hFFFFF, 5'd31);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd7, 5'd4);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd7, 5'd4);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd16, 5'd4);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd0, 5'd20);
    send_beat(bab_pkg::FuncAlloc, 21'd1048568, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd1048569, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd0, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd0, 5'd20);
    send_beat(bab_pkg::FuncFree, 21'd0, 20'h80000, 5'd19);
    send_beat(bab_pkg::FuncAlloc, 21'd524280, 20'd0, 5'd0);
    send_beat(bab_pkg::FuncAlloc, 21'd524280, 20'd0, 5'd0);
    drain();
    live_off.delete();
    live_ord.delete();
    send_beat(bab_pkg::FuncFree, 21'd0, 20'd0, 5'd20);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 54 : (ph == 3 ? 17 : 0);
      stall_pct     = (ph == 2) ? 54 : 0;
      if (ph == 3) begin
        send_idle_pct = 17;
        stall_pct = 17;
      end
      for (i = 0; i < 230; i++) random_beat();
      drain();
    end

    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      for (i = 0; i < 8; i++) random_beat();
    join
    drain();

    if (fail_count == 0) $display("buddy_allocator_bitmap regression: pass");
    else $display("buddy_allocator_bitmap regression: fail");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/bab_pkg.sv
hw/rtl/buddy_allocator_bitmap.sv
tb/bab_checker.sv
tb/tb_buddy_allocator_bitmap.sv
